// ----- rtl/npl_pkg.sv -----
package npl_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_QUERY = 2'd2
    } t_op;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load_item;
        logic clear_table;
        logic add_entry;
        logic scan_start;
        logic scan_step;
        logic cache_update;
        logic result_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] op;
        logic       cache_hit;
        logic       table_empty;
        logic       scan_last;
        logic       pipe_busy;
        logic       out_free;
    } t_dp_status;

endpackage

// ----- rtl/npl_ram.sv -----
module npl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/npl_ctrl.sv -----
module npl_ctrl
    import npl_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                if (i_status.op == OP_QUERY && !i_status.cache_hit) begin
                    n_state = i_status.table_empty ? S_DRAIN : S_SCAN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                if (i_status.scan_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                if (!i_status.pipe_busy) n_state = S_DONE;
            end
            S_DONE: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.load_item = i_in_valid;
            end
            S_EXEC: begin
                case (i_status.op)
                    OP_CLEAR: o_cmd.clear_table = 1'b1;
                    OP_ADD:   o_cmd.add_entry   = 1'b1;
                    OP_QUERY: o_cmd.scan_start  = !i_status.cache_hit;
                    default:  o_cmd = '0;
                endcase
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
            end
            S_DRAIN: begin
                o_cmd.cache_update = !i_status.pipe_busy;
            end
            S_DONE: begin
                o_cmd.result_load = i_status.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !i_status.table_empty)
        else $error("scan running on an empty table");
`endif

endmodule

// ----- rtl/npl_dpath.sv -----
module npl_dpath
    import npl_pkg::*;
#(
    parameter int MAX_ENTRIES = 64,
    parameter int COORD_BITS  = 20,
    parameter int TAG_BITS    = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_dp_cmd                      i_cmd,
    output t_dp_status                   o_status,
    input  logic [1:0]                   i_op,
    input  logic signed [COORD_BITS-1:0] i_pos_x,
    input  logic signed [COORD_BITS-1:0] i_pos_y,
    input  logic signed [COORD_BITS-1:0] i_pos_z,
    input  logic [TAG_BITS-1:0]          i_entry_tag,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_found,
    output logic [TAG_BITS-1:0]          o_nearest_tag,
    output logic [1:0]                   o_res_status
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int ENT_W = 3 * COORD_BITS + TAG_BITS;
    localparam int DIF_W = COORD_BITS + 1;
    localparam int SQ_W  = 2 * DIF_W;
    localparam int SUM_W = SQ_W + 2;

    // latched request
    logic [1:0]                   r_op;
    logic signed [COORD_BITS-1:0] r_qx, r_qy, r_qz;
    logic [TAG_BITS-1:0]          r_qtag;

    // table and cache
    logic [CNT_W-1:0]             r_count;
    logic                         r_add_drop;
    logic signed [COORD_BITS-1:0] r_last_x, r_last_y, r_last_z;
    logic                         r_cache_valid;
    logic                         r_cached_found;
    logic [TAG_BITS-1:0]          r_cached_tag;

    // scan pipeline
    logic [CNT_W-1:0]    r_rd_idx;
    logic                r_v1, r_v2;
    logic [SQ_W-1:0]     r_sq_x, r_sq_y, r_sq_z;
    logic [TAG_BITS-1:0] r_tag2;
    logic                r_have;
    logic [SUM_W-1:0]    r_best;
    logic [TAG_BITS-1:0] r_best_tag;

    // result register
    logic                r_out_valid;
    logic                r_out_found;
    logic [TAG_BITS-1:0] r_out_tag;
    logic [1:0]          r_out_status;

    logic                         table_full;
    logic                         cache_hit;
    logic [ENT_W-1:0]             ram_wdata;
    logic [ENT_W-1:0]             ram_rdata;
    logic signed [COORD_BITS-1:0] rd_x, rd_y, rd_z;
    logic [TAG_BITS-1:0]          rd_tag;
    logic signed [DIF_W-1:0]      dx, dy, dz;
    logic [DIF_W-1:0]             ax, ay, az;
    logic [SUM_W-1:0]             sq_dist;
    logic                         out_free;

    assign table_full = (r_count == CNT_W'(MAX_ENTRIES));
    assign cache_hit  = r_cache_valid && (r_last_x == r_qx) && (r_last_y == r_qy)
                        && (r_last_z == r_qz);
    assign out_free   = !r_out_valid || i_out_ready;

    assign o_status.op          = r_op;
    assign o_status.cache_hit   = cache_hit;
    assign o_status.table_empty = (r_count == '0);
    assign o_status.scan_last   = (r_rd_idx == r_count - CNT_W'(1));
    assign o_status.pipe_busy   = r_v1 || r_v2;
    assign o_status.out_free    = out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_op   <= i_op;
            r_qx   <= i_pos_x;
            r_qy   <= i_pos_y;
            r_qz   <= i_pos_z;
            r_qtag <= i_entry_tag;
        end
    end

    // point store, one entry per address: {tag, z, y, x}
    assign ram_wdata = {r_qtag, r_qz, r_qy, r_qx};

    npl_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_ENTRIES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.add_entry && !table_full),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.scan_step),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.clear_table) begin
            r_count <= '0;
        end else if (i_cmd.add_entry && !table_full) begin
            r_count <= r_count + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.add_entry) begin
            r_add_drop <= table_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cache_valid  <= 1'b0;
            r_cached_found <= 1'b0;
            r_cached_tag   <= '0;
            r_last_x       <= '0;
            r_last_y       <= '0;
            r_last_z       <= '0;
        end else if (i_cmd.clear_table) begin
            r_cache_valid  <= 1'b0;
            r_cached_found <= 1'b0;
            r_cached_tag   <= '0;
        end else if (i_cmd.cache_update) begin
            r_cache_valid  <= 1'b1;
            r_cached_found <= r_have;
            r_cached_tag   <= r_have ? r_best_tag : '0;
            r_last_x       <= r_qx;
            r_last_y       <= r_qy;
            r_last_z       <= r_qz;
        end
    end

    // stage 1: read address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.scan_step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_rd_idx <= '0;
        end else if (i_cmd.scan_step) begin
            r_rd_idx <= r_rd_idx + CNT_W'(1);
        end
    end

    // stage 2: per-axis squares
    assign rd_x   = ram_rdata[COORD_BITS-1:0];
    assign rd_y   = ram_rdata[2*COORD_BITS-1:COORD_BITS];
    assign rd_z   = ram_rdata[3*COORD_BITS-1:2*COORD_BITS];
    assign rd_tag = ram_rdata[ENT_W-1:3*COORD_BITS];

    assign dx = DIF_W'(rd_x) - DIF_W'(r_qx);
    assign dy = DIF_W'(rd_y) - DIF_W'(r_qy);
    assign dz = DIF_W'(rd_z) - DIF_W'(r_qz);
    assign ax = dx[DIF_W-1] ? DIF_W'(-dx) : DIF_W'(dx);
    assign ay = dy[DIF_W-1] ? DIF_W'(-dy) : DIF_W'(dy);
    assign az = dz[DIF_W-1] ? DIF_W'(-dz) : DIF_W'(dz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_sq_x <= ax * ax;
            r_sq_y <= ay * ay;
            r_sq_z <= az * az;
            r_tag2 <= rd_tag;
        end
    end

    // stage 3: sum and keep the strictly smaller distance, so ties stay earliest
    assign sq_dist = SUM_W'(r_sq_x) + SUM_W'(r_sq_y) + SUM_W'(r_sq_z);

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_start) begin
            r_have <= 1'b0;
        end else if (r_v2 && (!r_have || sq_dist < r_best)) begin
            r_have     <= 1'b1;
            r_best     <= sq_dist;
            r_best_tag <= r_tag2;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.result_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.result_load) begin
            case (r_op)
                OP_QUERY: begin
                    r_out_found  <= r_cached_found;
                    r_out_tag    <= r_cached_found ? r_cached_tag : '0;
                    r_out_status <= r_cached_found ? ST_OK : ST_EMPTY;
                end
                OP_ADD: begin
                    r_out_found  <= 1'b0;
                    r_out_tag    <= '0;
                    r_out_status <= r_add_drop ? ST_FULL : ST_OK;
                end
                default: begin
                    r_out_found  <= 1'b0;
                    r_out_tag    <= '0;
                    r_out_status <= ST_OK;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_found       = r_out_found;
    assign o_nearest_tag = r_out_tag;
    assign o_res_status  = r_out_status;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ENTRIES))
        else $error("entry count beyond table depth");
    a_pipe_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> $past(r_v1))
        else $error("square stage valid without a read the cycle before");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.result_load |-> out_free)
        else $error("result loaded over an untaken result");
`endif

endmodule

// ----- rtl/nearest_point_lookup.sv -----
// Channel   Dir  Handshake                        Payload (lowest bit first)
// request   in   i_s_axis_tvalid/o_s_axis_tready  tdata: pos_x, pos_y, pos_z, entry_tag
//                                                 tuser: operation
// result    out  o_m_axis_tvalid/i_m_axis_tready  tdata: nearest_tag; tuser: found, status
//
// Clear, add and cached queries pass from accept through the execute state to the result register.
// A searched query reads one table entry per cycle from the single read port of the
// point store, then a three-stage pipeline (read, square, sum and compare) drains.
// Reset (i_rst_n low, synchronous) empties the table and drops the cache.
// A new request is taken while an earlier result still waits on the output.
module nearest_point_lookup
    import npl_pkg::*;
#(
    parameter int MAX_ENTRIES = 64,
    parameter int COORD_BITS  = 20,
    parameter int TAG_BITS    = 16,
    localparam int IN_DATA_W  = ((3 * COORD_BITS + TAG_BITS + 7) / 8) * 8,
    localparam int OUT_DATA_W = ((TAG_BITS + 7) / 8) * 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,   // pos_x, pos_y, pos_z, entry_tag, zero pad
    input  logic [1:0]            i_s_axis_tuser,   // operation
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,   // nearest_tag, zero pad
    output logic [2:0]            o_m_axis_tuser    // found, status
);

    t_dp_cmd    cmd;
    t_dp_status status;

    logic                res_found;
    logic [TAG_BITS-1:0] res_tag;
    logic [1:0]          res_status;

    // controller: sequences clear, add, cache check and the table scan
    npl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath: point store, cache, distance pipeline, result register
    npl_dpath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .COORD_BITS  (COORD_BITS),
        .TAG_BITS    (TAG_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_op          (i_s_axis_tuser),
        .i_pos_x       (i_s_axis_tdata[COORD_BITS-1:0]),
        .i_pos_y       (i_s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_pos_z       (i_s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .i_entry_tag   (i_s_axis_tdata[3*COORD_BITS+TAG_BITS-1:3*COORD_BITS]),
        .o_out_valid   (o_m_axis_tvalid),
        .i_out_ready   (i_m_axis_tready),
        .o_found       (res_found),
        .o_nearest_tag (res_tag),
        .o_res_status  (res_status)
    );

    // pack the result; upper tdata bits stay zero
    assign o_m_axis_tdata = OUT_DATA_W'(res_tag);
    assign o_m_axis_tuser = {res_status, res_found};

endmodule
